// ----- hw/rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int DATA_BITS       = 8;
    localparam int DEF_TICK_WIDTH  = 8;
    localparam int CFG_W           = 8;
    localparam int CFG_ADDR_W      = 2;
    localparam int IN_DATA_W       = 16;   // write_data + sda_in, byte padded
    localparam int OUT_DATA_W      = 16;   // six flags + read_data, byte padded
    localparam int CMD_W           = 3;
    localparam int PHASE_W         = 5;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SETUP = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD  = 2'd2;

    localparam logic [CFG_W-1:0] SETUP_RST = 8'd3;
    localparam logic [CFG_W-1:0] HIGH_RST  = 8'd5;
    localparam logic [CFG_W-1:0] HOLD_RST  = 8'd1;

    // commands
    localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE     = 5'd0;
    localparam logic [PHASE_W-1:0] PH_ST_PREP  = 5'd1;
    localparam logic [PHASE_W-1:0] PH_ST_HIGH  = 5'd2;
    localparam logic [PHASE_W-1:0] PH_ST_FALL  = 5'd3;
    localparam logic [PHASE_W-1:0] PH_ST_HOLD  = 5'd4;
    localparam logic [PHASE_W-1:0] PH_WB_SETUP = 5'd5;
    localparam logic [PHASE_W-1:0] PH_WB_HIGH  = 5'd6;
    localparam logic [PHASE_W-1:0] PH_WB_HOLD  = 5'd7;
    localparam logic [PHASE_W-1:0] PH_WA_SETUP = 5'd8;
    localparam logic [PHASE_W-1:0] PH_WA_HIGH  = 5'd9;
    localparam logic [PHASE_W-1:0] PH_WA_HOLD  = 5'd10;
    localparam logic [PHASE_W-1:0] PH_RB_SETUP = 5'd11;
    localparam logic [PHASE_W-1:0] PH_RB_HIGH  = 5'd12;
    localparam logic [PHASE_W-1:0] PH_RB_HOLD  = 5'd13;
    localparam logic [PHASE_W-1:0] PH_MA_SETUP = 5'd14;
    localparam logic [PHASE_W-1:0] PH_MA_HIGH  = 5'd15;
    localparam logic [PHASE_W-1:0] PH_MA_HOLD  = 5'd16;
    localparam logic [PHASE_W-1:0] PH_SP_SETUP = 5'd17;
    localparam logic [PHASE_W-1:0] PH_SP_HIGH  = 5'd18;
    localparam logic [PHASE_W-1:0] PH_SP_FALL  = 5'd19;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [DATA_BITS-1:0] write_data;
        logic                 last;
        logic                 sda_in;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] setup_ticks;
        logic [CFG_W-1:0] high_ticks;
        logic [CFG_W-1:0] hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic                 scl;
        logic                 sda_level;
        logic                 sda_release;
        logic                 busy_res;
        logic                 done_res;
        logic                 nack_seen;
        logic [DATA_BITS-1:0] read_data;
    } res_t;

endpackage

// ----- hw/rtl/i2cm_seq.sv -----
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus phase sequencer: holds the transfer state and advances it one tick
// per step, producing the line levels and status for that tick.
// ----------------------------------------------------------------------------
module i2cm_seq #(
    parameter int TICK_WIDTH = i2cm_pkg::DEF_TICK_WIDTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  i2cm_pkg::item_t item,
    input  i2cm_pkg::cfg_t  cfg,
    output i2cm_pkg::res_t  result
);
    import i2cm_pkg::*;

    localparam longint unsigned TickMax = (64'd1 << TICK_WIDTH) - 64'd1;

    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [TICK_WIDTH-1:0] tick_reg, tick_next;
    logic [3:0]            bit_reg, bit_next;
    logic [DATA_BITS-1:0]  shift_reg, shift_next;
    logic                  last_pend_reg, last_pend_next;
    logic                  nack_reg, nack_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  rd_op_reg, rd_op_next;

    function automatic logic [TICK_WIDTH-1:0] ticks_of(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] t;
        t = (v == '0) ? CFG_W'(1) : v;
        if (64'(t) > TickMax)
            ticks_of = '1;
        else
            ticks_of = TICK_WIDTH'(t);
    endfunction

    function automatic logic [TICK_WIDTH-1:0] phase_len(input logic [PHASE_W-1:0] ph,
                                                        input cfg_t c);
        logic [TICK_WIDTH-1:0] len;
        unique case (ph)
            PH_ST_PREP, PH_WB_SETUP, PH_WA_SETUP,
            PH_RB_SETUP, PH_MA_SETUP, PH_SP_SETUP: len = ticks_of(c.setup_ticks);
            PH_ST_HOLD, PH_WB_HOLD, PH_WA_HOLD,
            PH_RB_HOLD, PH_MA_HOLD:                len = ticks_of(c.hold_ticks);
            default:                               len = ticks_of(c.high_ticks);
        endcase
        phase_len = len;
    endfunction

    logic                 rel;
    logic                 done;
    logic [PHASE_W-1:0]   np;

    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        last_pend_next = last_pend_reg;
        nack_next      = nack_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        rd_op_next     = rd_op_reg;
        done           = 1'b0;
        np             = PH_IDLE;

        // command decode, only while idle; unknown codes are no-ops
        if (phase_next == PH_IDLE)
        begin
            unique case (item.command)
                CMD_START: phase_next = PH_ST_PREP;
                CMD_WRITE:
                begin
                    phase_next = PH_WB_SETUP;
                    shift_next = item.write_data;
                end
                CMD_READ:
                begin
                    phase_next = PH_RB_SETUP;
                    shift_next = '0;
                end
                CMD_STOP:  phase_next = PH_SP_SETUP;
                default:   ;
            endcase
            if (phase_next != PH_IDLE)
            begin
                nack_next      = 1'b0;
                bit_next       = '0;
                last_pend_next = item.last;
                rd_op_next     = (item.command == CMD_READ);
                tick_next      = phase_len(phase_next, cfg);
            end
        end

        rel = (phase_next >= PH_WA_SETUP) && (phase_next <= PH_RB_HOLD);

        if (phase_next != PH_IDLE)
        begin
            // line levels for the phase active this tick
            unique case (phase_next)
                PH_ST_PREP:  sda_next = 1'b1;
                PH_ST_HIGH:  begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_ST_FALL:  begin scl_next = 1'b1; sda_next = 1'b0; end
                PH_ST_HOLD:  begin scl_next = 1'b0; sda_next = 1'b0; end
                PH_WB_SETUP, PH_WB_HOLD:
                begin
                    scl_next = 1'b0;
                    sda_next = shift_next[DATA_BITS-1];
                end
                PH_WB_HIGH:
                begin
                    scl_next = 1'b1;
                    sda_next = shift_next[DATA_BITS-1];
                end
                PH_WA_SETUP, PH_WA_HOLD, PH_RB_SETUP, PH_RB_HOLD:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                end
                PH_WA_HIGH, PH_RB_HIGH: begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_MA_SETUP, PH_MA_HOLD:
                begin
                    scl_next = 1'b0;
                    sda_next = last_pend_next;
                end
                PH_MA_HIGH:  begin scl_next = 1'b1; sda_next = last_pend_next; end
                PH_SP_SETUP: begin scl_next = 1'b0; sda_next = 1'b0; end
                PH_SP_HIGH:  begin scl_next = 1'b1; sda_next = 1'b0; end
                PH_SP_FALL:  begin scl_next = 1'b1; sda_next = 1'b1; end
                default:     ;
            endcase

            tick_next = tick_next - TICK_WIDTH'(1);

            if (tick_next == '0)
            begin
                unique case (phase_next)
                    PH_ST_PREP:  np = PH_ST_HIGH;
                    PH_ST_HIGH:  np = PH_ST_FALL;
                    PH_ST_FALL:  np = PH_ST_HOLD;
                    PH_WB_SETUP: np = PH_WB_HIGH;
                    PH_WB_HIGH:  np = PH_WB_HOLD;
                    PH_WB_HOLD:
                    begin
                        shift_next = {shift_next[DATA_BITS-2:0], 1'b0};
                        bit_next   = bit_next + 4'd1;
                        np = (bit_next >= 4'(DATA_BITS)) ? PH_WA_SETUP : PH_WB_SETUP;
                    end
                    PH_WA_SETUP: np = PH_WA_HIGH;
                    PH_WA_HIGH:
                    begin
                        nack_next = item.sda_in;   // ack sampled at end of SCL high
                        np        = PH_WA_HOLD;
                    end
                    PH_WA_HOLD:
                    begin
                        if (nack_next || last_pend_next)
                            np = PH_SP_SETUP;
                        else
                            done = 1'b1;
                    end
                    PH_RB_SETUP: np = PH_RB_HIGH;
                    PH_RB_HIGH:
                    begin
                        shift_next = {shift_next[DATA_BITS-2:0], item.sda_in};
                        np         = PH_RB_HOLD;
                    end
                    PH_RB_HOLD:
                    begin
                        bit_next = bit_next + 4'd1;
                        np = (bit_next >= 4'(DATA_BITS)) ? PH_MA_SETUP : PH_RB_SETUP;
                    end
                    PH_MA_SETUP: np = PH_MA_HIGH;
                    PH_MA_HIGH:  np = PH_MA_HOLD;
                    PH_MA_HOLD:
                    begin
                        if (last_pend_next)
                            np = PH_SP_SETUP;
                        else
                            done = 1'b1;
                    end
                    PH_SP_SETUP: np = PH_SP_HIGH;
                    PH_SP_HIGH:  np = PH_SP_FALL;
                    default:     done = 1'b1;
                endcase
                phase_next = np;
                tick_next  = (np == PH_IDLE) ? '0 : phase_len(np, cfg);
            end
        end

        result.scl         = scl_next;
        result.sda_level   = rel ? 1'b1 : sda_next;
        result.sda_release = rel;
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = done;
        result.nack_seen   = done && !rd_op_next && nack_next;
        result.read_data   = (done && rd_op_next) ? shift_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            last_pend_reg <= 1'b0;
            nack_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            rd_op_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            last_pend_reg <= last_pend_next;
            nack_reg      <= nack_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            rd_op_reg     <= rd_op_next;
        end
    end

endmodule

// ----- hw/rtl/i2c_master_byte_engine_core.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core
// I2C master that advances one bus tick per input word.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one word per bus tick: tuser = command, tlast = last byte,
//   tdata = write_data and the sampled SDA level. Commands are taken only
//   while the engine is idle; otherwise the word just advances the tick.
//   m_* returns one word per input word with SCL, SDA drive/release, busy,
//   done pulse, nack and the received byte.
//   cfg_we/cfg_addr/cfg_wdata write the setup, high and hold tick counts;
//   write them only while no transfer is running.
// Timing:
//   Input register, one pass of sequencer logic, output register. A taken
//   word is held in the input register, and its result is registered in the
//   output register when the word steps; one word per cycle sustained while
//   m_tready stays high.
// Reset:
//   Engine idle, SCL and SDA high, tick counts 3/5/1, both channels empty.
// Stalls:
//   A stalled m_tready holds the result word; one more input word is
//   buffered, after which s_tready drops until the output drains.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_core #(
    parameter int TICK_WIDTH = i2cm_pkg::DEF_TICK_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // cfg
    input  logic                              cfg_we,
    input  logic [i2cm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [i2cm_pkg::CFG_W-1:0]        cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [i2cm_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] write_data, [8] sda_in
    input  logic [i2cm_pkg::CMD_W-1:0]        s_tuser,   // [2:0] command
    input  logic                              s_tlast,
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [i2cm_pkg::OUT_DATA_W-1:0]   m_tdata    // [0] scl, [1] sda_level,
                                                         // [2] sda_release, [3] busy_res,
                                                         // [4] done_res, [5] nack_seen,
                                                         // [13:6] read_data
);
    import i2cm_pkg::*;

    cfg_t  cfg_reg;
    item_t item_reg;
    logic  in_valid_reg, in_valid_next;
    logic  out_valid_reg, out_valid_next;
    res_t  res_reg;
    res_t  res_comb;
    logic  step;
    logic  take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setup_ticks <= SETUP_RST;
            cfg_reg.high_ticks  <= HIGH_RST;
            cfg_reg.hold_ticks  <= HOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SETUP: cfg_reg.setup_ticks <= cfg_wdata;
                REG_HIGH:  cfg_reg.high_ticks  <= cfg_wdata;
                REG_HOLD:  cfg_reg.hold_ticks  <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.command    <= s_tuser;
            item_reg.write_data <= s_tdata[DATA_BITS-1:0];
            item_reg.last       <= s_tlast;
            item_reg.sda_in     <= s_tdata[DATA_BITS];
        end
        if (step)
            res_reg <= res_comb;
    end

    i2cm_seq #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (res_comb)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - DATA_BITS - 6){1'b0}},
                       res_reg.read_data,
                       res_reg.nack_seen,
                       res_reg.done_res,
                       res_reg.busy_res,
                       res_reg.sda_release,
                       res_reg.sda_level,
                       res_reg.scl};

endmodule

// ----- hw/rtl/i2cm_checker.sv -----
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the result stream of the I2C master byte engine.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [i2cm_pkg::OUT_DATA_W-1:0] m_tdata
);
    import i2cm_pkg::*;

    // a completing word never reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> !m_tdata[3])
        else $error("done with busy set");

    // released SDA always reads back as high level
    a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[1])
        else $error("released SDA not high");

    // nack and read byte are only reported with done
    a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[4] |-> (m_tdata[DATA_BITS+5:5] == '0))
        else $error("status without done");

    // stalled word holds
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

endmodule

bind i2c_master_byte_engine_core i2cm_checker u_i2cm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C master byte engine. Each stream word is one
// bus tick; a cycle-level copy of the sequencer predicts every result word.
// A short scripted walk covers idle, unknown codes, bare commands, repeated
// start, nack and last-byte stops. Randomized transfers then run under
// several tick settings with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;

    import i2cm_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int PLAN_COUNT  = 4;
    localparam int PLAN_TICKS  = 40;

    // codes with no meaning to the engine
    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]     cmd;
        logic [DATA_BITS-1:0] wdata;
        logic                 last;
        logic [DATA_BITS-1:0] slave;    // byte returned on reads, bit 0 = ack level
        logic [CMD_W-1:0]     filler;   // command offered while the engine is busy
        bit                   typed;
        logic [3:0]           lines;    // {busy, release, sda, scl} on the command tick
    } step_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    // shadow of the sequencer
    logic [CFG_W-1:0]            cfg_setup;
    logic [CFG_W-1:0]            cfg_high;
    logic [CFG_W-1:0]            cfg_hold;
    logic [PHASE_W-1:0]          seq_phase;
    logic [DEF_TICK_WIDTH-1:0]   seq_ticks;
    logic [3:0]                  seq_bits;
    logic [DATA_BITS-1:0]        seq_shift;
    logic                        seq_last;
    logic                        seq_nack;
    logic                        seq_is_read;
    logic                        line_scl;
    logic                        line_sda;

    res_t pending_ticks [$];
    int   mismatches;
    int   sent_count;
    int   quiet_cycles;
    int   hold_left;
    bit   hold_off_req;
    bit   tx_steady;
    bit   rx_steady;

    step_row_t script [24] = '{
        '{CMD_NONE,  8'h00, 1'b0, 8'h00, CMD_NONE,  1'b1, 4'b0011},
        '{CMD_RSVD5, 8'h00, 1'b0, 8'h00, CMD_NONE,  1'b1, 4'b0011},
        '{CMD_RSVD6, 8'h5A, 1'b0, 8'h01, CMD_NONE,  1'b1, 4'b0011},
        '{CMD_RSVD7, 8'hFF, 1'b1, 8'hFF, CMD_NONE,  1'b1, 4'b0011},
        '{CMD_STOP,  8'h00, 1'b0, 8'h00, CMD_START, 1'b1, 4'b1000},
        '{CMD_START, 8'h00, 1'b0, 8'h00, CMD_NONE,  1'b1, 4'b1011},
        '{CMD_WRITE, 8'hA5, 1'b0, 8'h00, CMD_NONE,  1'b1, 4'b1010},
        '{CMD_WRITE, 8'h00, 1'b0, 8'h01, CMD_NONE,  1'b1, 4'b1000},
        '{CMD_START, 8'hFF, 1'b1, 8'hFF, CMD_NONE,  1'b1, 4'b1011},
        '{CMD_WRITE, 8'hFF, 1'b1, 8'h00, CMD_NONE,  1'b1, 4'b1010},
        '{CMD_START, 8'h00, 1'b0, 8'h00, CMD_NONE,  1'b1, 4'b1011},
        '{CMD_WRITE, 8'h5A, 1'b0, 8'h00, CMD_NONE,  1'b1, 4'b1000},
        '{CMD_START, 8'h00, 1'b0, 8'h00, CMD_NONE,  1'b1, 4'b1010},
        '{CMD_READ,  8'h00, 1'b0, 8'hFF, CMD_NONE,  1'b1, 4'b1110},
        '{CMD_READ,  8'hFF, 1'b0, 8'h00, CMD_NONE,  1'b1, 4'b1110},
        '{CMD_READ,  8'h00, 1'b1, 8'h3C, CMD_NONE,  1'b1, 4'b1110},
        '{CMD_READ,  8'h00, 1'b1, 8'hC3, CMD_NONE,  1'b1, 4'b1110},
        '{CMD_WRITE, 8'h01, 1'b1, 8'h01, CMD_NONE,  1'b1, 4'b1000},
        '{CMD_START, 8'h00, 1'b0, 8'h00, CMD_NONE,  1'b1, 4'b1011},
        '{CMD_READ,  8'h00, 1'b0, 8'h81, CMD_NONE,  1'b1, 4'b1110},
        '{CMD_STOP,  8'h00, 1'b0, 8'h00, CMD_NONE,  1'b1, 4'b1000},
        '{CMD_START, 8'h00, 1'b0, 8'h00, CMD_WRITE, 1'b1, 4'b1011},
        '{CMD_WRITE, 8'h80, 1'b1, 8'h00, CMD_READ,  1'b1, 4'b1010},
        '{CMD_STOP,  8'h00, 1'b0, 8'h00, CMD_RSVD7, 1'b1, 4'b1000}
    };

    i2c_master_byte_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // [7:0] write_data, [8] sda_in
        .s_tuser   (s_tuser),      // [2:0] command
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)       // [0] scl, [1] sda_level, [2] sda_release,
                                   // [3] busy_res, [4] done_res, [5] nack_seen,
                                   // [13:6] read_data
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic void enter_phase(logic [PHASE_W-1:0] ph);
        logic [CFG_W-1:0] len;
        case (ph)
            PH_ST_PREP, PH_WB_SETUP, PH_WA_SETUP, PH_RB_SETUP, PH_MA_SETUP, PH_SP_SETUP:
                len = cfg_setup;
            PH_ST_HOLD, PH_WB_HOLD, PH_WA_HOLD, PH_RB_HOLD, PH_MA_HOLD:
                len = cfg_hold;
            default:
                len = cfg_high;
        endcase
        seq_phase = ph;
        // a zero register still gives a one-tick phase
        seq_ticks = (ph == PH_IDLE) ? '0 : ((len == '0) ? 8'd1 : len);
    endfunction

    // One bus tick of the engine: takes a command when idle, drives the
    // lines for the current phase and moves on when its ticks run out.
    function automatic res_t bus_tick(item_t w);
        res_t               r;
        logic [PHASE_W-1:0] cur;
        logic               rel;
        logic               fin;
        fin = 1'b0;
        if (seq_phase == PH_IDLE && w.command >= CMD_START && w.command <= CMD_STOP)
        begin
            seq_nack    = 1'b0;
            seq_bits    = '0;
            seq_last    = w.last;
            seq_is_read = (w.command == CMD_READ);
            case (w.command)
                CMD_START: enter_phase(PH_ST_PREP);
                CMD_WRITE:
                begin
                    seq_shift = w.write_data;
                    enter_phase(PH_WB_SETUP);
                end
                CMD_READ:
                begin
                    seq_shift = '0;
                    enter_phase(PH_RB_SETUP);
                end
                default: enter_phase(PH_SP_SETUP);
            endcase
        end
        cur = seq_phase;
        rel = (cur >= PH_WA_SETUP && cur <= PH_RB_HOLD);
        if (cur != PH_IDLE)
        begin
            case (cur)
                PH_ST_PREP: line_sda = 1'b1;    // SCL left as it is
                PH_ST_HIGH: begin line_scl = 1'b1; line_sda = 1'b1; end
                PH_ST_FALL: begin line_scl = 1'b1; line_sda = 1'b0; end
                PH_ST_HOLD: begin line_scl = 1'b0; line_sda = 1'b0; end
                PH_WB_SETUP, PH_WB_HOLD:
                    begin line_scl = 1'b0; line_sda = seq_shift[DATA_BITS-1]; end
                PH_WB_HIGH: begin line_scl = 1'b1; line_sda = seq_shift[DATA_BITS-1]; end
                PH_WA_SETUP, PH_WA_HOLD, PH_RB_SETUP, PH_RB_HOLD:
                    begin line_scl = 1'b0; line_sda = 1'b1; end
                PH_WA_HIGH, PH_RB_HIGH: begin line_scl = 1'b1; line_sda = 1'b1; end
                PH_MA_SETUP, PH_MA_HOLD: begin line_scl = 1'b0; line_sda = seq_last; end
                PH_MA_HIGH: begin line_scl = 1'b1; line_sda = seq_last; end
                PH_SP_SETUP: begin line_scl = 1'b0; line_sda = 1'b0; end
                PH_SP_HIGH: begin line_scl = 1'b1; line_sda = 1'b0; end
                default: begin line_scl = 1'b1; line_sda = 1'b1; end
            endcase
            seq_ticks = seq_ticks - 1'b1;
            if (seq_ticks == '0)
            begin
                case (cur)
                    PH_WB_HOLD:
                    begin
                        seq_shift = seq_shift << 1;
                        seq_bits  = seq_bits + 1'b1;
                        enter_phase((seq_bits >= DATA_BITS) ? PH_WA_SETUP : PH_WB_SETUP);
                    end
                    PH_WA_HIGH:
                    begin
                        seq_nack = w.sda_in;
                        enter_phase(PH_WA_HOLD);
                    end
                    PH_WA_HOLD:
                        if (seq_nack || seq_last) enter_phase(PH_SP_SETUP);
                        else fin = 1'b1;
                    PH_RB_HIGH:
                    begin
                        seq_shift = {seq_shift[DATA_BITS-2:0], w.sda_in};
                        enter_phase(PH_RB_HOLD);
                    end
                    PH_RB_HOLD:
                    begin
                        seq_bits = seq_bits + 1'b1;
                        enter_phase((seq_bits >= DATA_BITS) ? PH_MA_SETUP : PH_RB_SETUP);
                    end
                    PH_MA_HOLD:
                        if (seq_last) enter_phase(PH_SP_SETUP);
                        else fin = 1'b1;
                    PH_ST_HOLD, PH_SP_FALL:
                        fin = 1'b1;
                    // the remaining phases just step to the next code
                    default:
                        enter_phase(cur + 1'b1);
                endcase
                if (fin) enter_phase(PH_IDLE);
            end
        end
        r.scl         = line_scl;
        r.sda_level   = rel ? 1'b1 : line_sda;
        r.sda_release = rel;
        r.busy_res    = (seq_phase != PH_IDLE);
        r.done_res    = fin;
        r.nack_seen   = (fin && !seq_is_read) ? seq_nack : 1'b0;
        r.read_data   = (fin && seq_is_read) ? seq_shift : '0;
        return r;
    endfunction

    // Level the slave puts on SDA for the phase about to be driven.
    function automatic logic slave_sda(logic [DATA_BITS-1:0] slave);
        case (seq_phase)
            PH_RB_SETUP, PH_RB_HIGH, PH_RB_HOLD: return slave[3'd7 - seq_bits[2:0]];
            PH_WA_SETUP, PH_WA_HIGH, PH_WA_HOLD: return slave[0];
            default: return ($urandom_range(0, 1) == 1);
        endcase
    endfunction

    task automatic send_tick(item_t w, bit typed, logic [3:0] lines);
        int   gap;
        res_t r;
        if (tx_steady) gap = 0;
        else if ($urandom_range(0, 39) == 0) gap = $urandom_range(6, 30);
        else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 2);
        else gap = 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = w.command;
        s_tlast  = w.last;
        s_tdata  = {7'd0, w.sda_in, w.write_data};
        do @(posedge clk); while (!s_tready);
        sent_count++;
        r = bus_tick(w);
        if (typed)
        begin
            r.scl         = lines[0];
            r.sda_level   = lines[1];
            r.sda_release = lines[2];
            r.busy_res    = lines[3];
            r.done_res    = 1'b0;
            r.nack_seen   = 1'b0;
            r.read_data   = '0;
        end
        pending_ticks.push_back(r);
    endtask

    // Offers one command, then filler words until the engine is idle again.
    task automatic run_command(logic [CMD_W-1:0] cmd, logic [DATA_BITS-1:0] wdata,
                               logic last, logic [DATA_BITS-1:0] slave,
                               logic [CMD_W-1:0] filler, bit typed, logic [3:0] lines);
        item_t w;
        w.command    = cmd;
        w.write_data = wdata;
        w.last       = last;
        w.sda_in     = slave_sda(slave);
        send_tick(w, typed, lines);
        while (seq_phase != PH_IDLE)
        begin
            w.command    = filler;
            w.write_data = 8'($urandom);
            w.last       = ($urandom_range(0, 1) == 1);
            w.sda_in     = slave_sda(slave);
            send_tick(w, 1'b0, 4'b0000);
        end
    endtask

    task automatic random_transfer();
        int                   nbytes;
        int                   k;
        bit                   rd;
        bit                   auto_end;
        bit                   nack;
        logic [CMD_W-1:0]     filler;
        filler = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : CMD_NONE;
        if ($urandom_range(0, 4) == 0)
        begin
            // stray word: idle tick, unknown code or a bare command
            run_command(3'($urandom_range(0, 7)), 8'($urandom), $urandom_range(0, 1) == 1,
                        8'($urandom), filler, 1'b0, 4'b0000);
            return;
        end
        run_command(CMD_START, 8'($urandom), $urandom_range(0, 1) == 1, 8'($urandom),
                    filler, 1'b0, 4'b0000);
        nbytes   = $urandom_range(1, 2);
        rd       = ($urandom_range(0, 1) == 1);
        auto_end = ($urandom_range(0, 1) == 1);
        for (k = 0; k < nbytes; k++)
        begin
            nack = !rd && ($urandom_range(0, 7) == 0);
            run_command(rd ? CMD_READ : CMD_WRITE, 8'($urandom), auto_end && k == nbytes - 1,
                        rd ? 8'($urandom) : {7'd0, nack}, filler, 1'b0, 4'b0000);
            if (nack) return;   // engine already sent the stop
            if (k < nbytes - 1 && $urandom_range(0, 5) == 0)
            begin
                run_command(CMD_START, 8'($urandom), 1'b0, 8'($urandom), filler, 1'b0, 4'b0000);
                rd = !rd;
            end
        end
        // now and then leave the bus held with no stop
        if (!auto_end && $urandom_range(0, 7) != 0)
            run_command(CMD_STOP, 8'($urandom), $urandom_range(0, 1) == 1, 8'($urandom),
                        filler, 1'b0, 4'b0000);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_ticks.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_SETUP: cfg_setup = val;
            REG_HIGH:  cfg_high  = val;
            default:   cfg_hold  = val;
        endcase
    endtask

    task automatic check_field(string name, logic [DATA_BITS-1:0] want,
                               logic [DATA_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // result word checker
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_ticks.size() == 0)
            begin
                $error("result word %h with nothing expected", m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_ticks.pop_front();
                check_field("scl", 8'(want.scl), 8'(m_tdata[0]));
                check_field("sda_level", 8'(want.sda_level), 8'(m_tdata[1]));
                check_field("sda_release", 8'(want.sda_release), 8'(m_tdata[2]));
                check_field("busy_res", 8'(want.busy_res), 8'(m_tdata[3]));
                check_field("done_res", 8'(want.done_res), 8'(m_tdata[4]));
                check_field("nack_seen", 8'(want.nack_seen), 8'(m_tdata[5]));
                check_field("read_data", want.read_data, m_tdata[13:6]);
            end
        end
    end

    // watchdog on cycles with no word moving on either stream
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = LONG_HOLD;
            end
            else if (hold_left == 0 && !rx_steady)
            begin
                if ($urandom_range(0, 39) == 0) hold_left = $urandom_range(6, 30);
                else if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 2);
            end
            m_tready = (hold_left == 0);
            if (hold_left > 0) hold_left--;
        end
    end

    initial
    begin
        cfg_t plan [PLAN_COUNT];
        int   p;
        int   goal;
        bit   pressed;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_NONE;
        s_tlast      = 1'b0;
        cfg_setup    = SETUP_RST;
        cfg_high     = HIGH_RST;
        cfg_hold     = HOLD_RST;
        seq_phase    = PH_IDLE;
        seq_ticks    = '0;
        seq_bits     = '0;
        seq_shift    = '0;
        seq_last     = 1'b0;
        seq_nack     = 1'b0;
        seq_is_read  = 1'b0;
        line_scl     = 1'b1;
        line_sda     = 1'b1;
        mismatches   = 0;
        sent_count   = 0;
        quiet_cycles = 0;
        hold_off_req = 1'b0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        pressed      = 1'b0;
        plan[0] = '{8'd2, 8'd3, 8'd1};
        plan[1] = '{8'd0, 8'd2, 8'd4};      // zero setup still lasts one tick
        plan[2] = '{8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
                    8'($urandom_range(1, 3))};
        plan[3] = '{SETUP_RST, HIGH_RST, HOLD_RST};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one-tick phases keep the scripted walk short
        write_reg(REG_SETUP, 8'd1);
        write_reg(REG_HIGH, 8'd1);
        write_reg(REG_HOLD, 8'd1);

        foreach (script[i])
            run_command(script[i].cmd, script[i].wdata, script[i].last, script[i].slave,
                        script[i].filler, script[i].typed, script[i].lines);
        drain_results();

        for (p = 0; p < PLAN_COUNT; p++)
        begin
            write_reg(REG_SETUP, plan[p].setup_ticks);
            write_reg(REG_HIGH, plan[p].high_ticks);
            write_reg(REG_HOLD, plan[p].hold_ticks);
            tx_steady = (p == 0) || ($urandom_range(0, 3) == 0);
            rx_steady = (p == 0) || ($urandom_range(0, 3) == 0);
            goal = sent_count + PLAN_TICKS;
            while (sent_count < goal)
            begin
                // long receiver hold-off while words keep coming in
                if (p == 1 && !pressed)
                begin
                    hold_off_req = 1'b1;
                    pressed      = 1'b1;
                end
                random_transfer();
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_seq.sv
hw/rtl/i2c_master_byte_engine_core.sv
hw/rtl/i2cm_checker.sv
tb/sv/testbench.sv
